// File: rtl/ssp_pkg.sv
// Shared types and constants for the sorted push stack.
// Used by ssp_cell, sorted_push_stack_top and ssp_checker; no dependencies.
`default_nettype none

package ssp_pkg;

    localparam int WORD_W      = 32;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int COUNT_OUT_W = 5;
    localparam int DEPTH_DEF   = 16;

    // stream layout
    localparam int S_TDATA_W = 32;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 2;

    typedef logic signed [WORD_W-1:0] word_t;

    typedef enum logic [OP_W-1:0] {
        OP_PUSH      = 2'd0,
        OP_POP       = 2'd1,
        OP_REVERSE   = 2'd2,
        OP_SORT_PUSH = 2'd3
    } op_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_DONE  = 2'd0,
        STAT_EMPTY = 2'd1,
        STAT_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        CELL_HOLD,
        CELL_PUSH,
        CELL_POP,
        CELL_SORT,
        CELL_REV
    } cell_cmd_t;

    // command broadcast to every cell of the row
    typedef struct packed {
        cell_cmd_t cmd;
        logic      phase;
    } cell_ctrl_t;

    typedef enum logic {
        FSM_IDLE,
        FSM_PASS
    } fsm_t;

endpackage

`default_nettype wire

// File: rtl/ssp_cell.sv
// One stack entry of the cell row: shifts for push/pop, compare-exchange
// or plain exchange with a neighbor during transposition passes. Uses ssp_pkg.
`default_nettype none

module ssp_cell #(
    parameter int CW  = 5,
    parameter int IDX = 0
) (
    input  wire logic               clk,
    input  wire ssp_pkg::cell_ctrl_t ctrl,
    input  wire logic [CW-1:0]      cnt,
    input  wire ssp_pkg::word_t     prv_data,
    input  wire ssp_pkg::word_t     nxt_data,
    output      ssp_pkg::word_t     data
);
    import ssp_pkg::*;

    localparam logic [CW-1:0] IDX_C = CW'(IDX);
    localparam logic [CW-1:0] NXT_C = CW'(IDX + 1);
    localparam bit            HAS_PRV_POS = (IDX > 0);

    word_t data_reg;
    word_t data_next;
    logic  has_nxt;
    logic  has_prv;
    logic  left_role;

    // cell 0 is the top of the stack
    assign has_nxt   = (NXT_C < cnt);
    assign has_prv   = HAS_PRV_POS && (IDX_C < cnt);
    assign left_role = (IDX_C[0] == ctrl.phase);

    always_comb
    begin
        data_next = data_reg;
        case (ctrl.cmd)
            CELL_PUSH: data_next = prv_data;
            CELL_POP:  data_next = nxt_data;
            CELL_SORT:
            begin
                // top side of a pair keeps the larger word
                if (left_role && has_nxt)
                begin
                    if (data_reg < nxt_data)
                        data_next = nxt_data;
                end
                else if (!left_role && has_prv)
                begin
                    if (prv_data < data_reg)
                        data_next = prv_data;
                end
            end
            CELL_REV:
            begin
                if (left_role && has_nxt)
                    data_next = nxt_data;
                else if (!left_role && has_prv)
                    data_next = prv_data;
            end
            default: data_next = data_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

`default_nettype wire

// File: rtl/sorted_push_stack_top.sv
// Sorted push stack: request decode, pass sequencer and output register
// around a row of ssp_cell entries. Uses ssp_pkg and ssp_cell.
//
// Usage:
//   Requests enter on s_* (s_tuser = operation, s_tdata = value). Each request
//   gives exactly one result on m_* (m_tdata = popped value and entry count,
//   m_tuser = status), registered at acceptance.
//   Push and pop run no passes. Reverse and sorted push then run odd-even
//   transposition passes over the cell row, one pass per cycle, one pass for
//   each entry after the operation if the stack then holds more than one entry.
//   The result is registered at acceptance, so it can be taken while the
//   passes run; the next request is taken once the passes have finished.
//   If the receiver stalls, the result holds in the output register and
//   s_tready stays low until it is taken.
//   Reset empties the stack and clears the output valid flag; entry words and
//   result fields are not cleared and no clearing pass is needed.
`default_nettype none

module sorted_push_stack_top #(
    parameter int DEPTH = ssp_pkg::DEPTH_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          s_tvalid,
    output      logic                          s_tready,
    input  wire logic [ssp_pkg::S_TDATA_W-1:0] s_tdata,  // [31:0] value
    input  wire logic [ssp_pkg::S_TUSER_W-1:0] s_tuser,  // [1:0] operation
    output      logic                          m_tvalid,
    input  wire logic                          m_tready,
    output      logic [ssp_pkg::M_TDATA_W-1:0] m_tdata,  // [31:0] popped_value,
                                                         // [36:32] entry_count
    output      logic [ssp_pkg::M_TUSER_W-1:0] m_tuser   // [1:0] status
);
    import ssp_pkg::*;

    localparam int CW = $clog2(DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(DEPTH);
    localparam logic [CW-1:0] ONE_C   = CW'(1);

    fsm_t             state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [CW-1:0]    pass_cnt_reg, pass_cnt_next;
    logic             sort_mode_reg, sort_mode_next;
    logic             m_tvalid_reg;
    word_t            popped_reg;
    status_t          status_reg;
    logic [COUNT_OUT_W-1:0] entry_count_reg;

    logic             acc;
    op_t              op;
    word_t            value;
    cell_cmd_t        item_cmd;
    status_t          item_status;
    word_t            item_popped;
    logic             start_pass;
    logic             item_sort;
    logic             last_pass;
    logic [CW+COUNT_OUT_W-1:0] cnt_ext;
    cell_ctrl_t       ctrl;

    word_t            cell_data [DEPTH];

    assign op    = op_t'(s_tuser[OP_W-1:0]);
    assign value = word_t'(s_tdata[WORD_W-1:0]);

    assign s_tready = (state_reg == FSM_IDLE) && (!m_tvalid_reg || m_tready);
    assign acc      = s_tvalid && s_tready;

    // request decode
    always_comb
    begin
        item_cmd    = CELL_HOLD;
        item_status = STAT_DONE;
        item_popped = '0;
        count_next  = count_reg;
        start_pass  = 1'b0;
        item_sort   = 1'b0;
        unique case (op)
            OP_PUSH, OP_SORT_PUSH:
            begin
                if (count_reg == DEPTH_C)
                    item_status = STAT_FULL;
                else
                begin
                    item_cmd   = CELL_PUSH;
                    count_next = count_reg + ONE_C;
                    item_sort  = 1'b1;
                    start_pass = (op == OP_SORT_PUSH) && (count_reg != '0);
                end
            end
            OP_POP:
            begin
                if (count_reg == '0)
                    item_status = STAT_EMPTY;
                else
                begin
                    item_cmd    = CELL_POP;
                    item_popped = cell_data[0];
                    count_next  = count_reg - ONE_C;
                end
            end
            OP_REVERSE:
            begin
                start_pass = (count_reg > ONE_C);
            end
            default: ;
        endcase
    end

    assign last_pass = (pass_cnt_reg == count_reg - ONE_C);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            FSM_IDLE: if (acc && start_pass) state_next = FSM_PASS;
            FSM_PASS: if (last_pass) state_next = FSM_IDLE;
            default:  state_next = FSM_IDLE;
        endcase
    end

    // outputs of the sequencer
    always_comb
    begin
        ctrl           = '{cmd: CELL_HOLD, phase: 1'b0};
        pass_cnt_next  = pass_cnt_reg;
        sort_mode_next = sort_mode_reg;
        unique case (state_reg)
            FSM_IDLE:
            begin
                if (acc)
                begin
                    ctrl.cmd       = item_cmd;
                    pass_cnt_next  = '0;
                    sort_mode_next = item_sort;
                end
            end
            FSM_PASS:
            begin
                ctrl.cmd      = sort_mode_reg ? CELL_SORT : CELL_REV;
                ctrl.phase    = pass_cnt_reg[0];
                pass_cnt_next = pass_cnt_reg + ONE_C;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            count_reg     <= '0;
            pass_cnt_reg  <= '0;
            sort_mode_reg <= 1'b0;
            m_tvalid_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_cnt_reg  <= pass_cnt_next;
            sort_mode_reg <= sort_mode_next;
            if (acc)
            begin
                count_reg    <= count_next;
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
                m_tvalid_reg <= 1'b0;
        end
    end

    assign cnt_ext = {{COUNT_OUT_W{1'b0}}, count_next};

    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            popped_reg      <= item_popped;
            status_reg      <= item_status;
            entry_count_reg <= cnt_ext[COUNT_OUT_W-1:0];
        end
    end

    // cell row, cell 0 holds the top entry
    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        word_t prv;
        word_t nxt;
        if (i == 0)
        begin : g_first
            assign prv = value;
        end
        else
        begin : g_mid_prv
            assign prv = cell_data[i-1];
        end
        if (i == DEPTH - 1)
        begin : g_last
            assign nxt = cell_data[i];
        end
        else
        begin : g_mid_nxt
            assign nxt = cell_data[i+1];
        end
        ssp_cell #(
            .CW  (CW),
            .IDX (i)
        ) u_cell (
            .clk      (clk),
            .ctrl     (ctrl),
            .cnt      (count_reg),
            .prv_data (prv),
            .nxt_data (nxt),
            .data     (cell_data[i])
        );
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {{(M_TDATA_W - WORD_W - COUNT_OUT_W){1'b0}}, entry_count_reg,
                       popped_reg};
    assign m_tuser  = status_reg;

endmodule

`default_nettype wire

// File: rtl/ssp_checker.sv
// Port-level checks for sorted_push_stack_top, attached by bind.
// Uses ssp_pkg.
`default_nettype none

module ssp_checker (
    input wire logic                          clk,
    input wire logic                          rst_n,
    input wire logic                          s_tvalid,
    input wire logic                          s_tready,
    input wire logic [ssp_pkg::S_TDATA_W-1:0] s_tdata,
    input wire logic [ssp_pkg::S_TUSER_W-1:0] s_tuser,
    input wire logic                          m_tvalid,
    input wire logic                          m_tready,
    input wire logic [ssp_pkg::M_TDATA_W-1:0] m_tdata,
    input wire logic [ssp_pkg::M_TUSER_W-1:0] m_tuser
);
    import ssp_pkg::*;

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result changed while stalled");

    // a waiting request holds until taken
    a_req_hold: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && !s_tready |=> s_tvalid && $stable(s_tdata) && $stable(s_tuser))
        else $error("request changed while waiting");

    // every request gives its result on the next cycle
    a_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("no result after request");

    // no request is taken while a stalled result would be overwritten
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |-> !m_tvalid || m_tready)
        else $error("request taken over a pending result");

    // only a good pop returns a word; an empty pop reports zero entries
    a_status: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != STAT_DONE |->
            m_tdata[31:0] == '0 && (m_tuser != STAT_EMPTY || m_tdata[36:32] == '0))
        else $error("result fields disagree with status");

endmodule

bind sorted_push_stack_top ssp_checker u_ssp_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
);

`default_nettype wire
